// File: src/bitmap_first_fit_frame_allocator_defines.svh
// ---------------------------------------------------------------------------
// Bitmap first-fit frame allocator: assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bffa_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap first-fit frame allocator: shared package
// Field widths, function codes, register selects, controller states and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package bffa_pkg;

  localparam int FrameW  = 18;
  localparam int SrcW    = 16;
  localparam int CountW  = 17;
  localparam int EndW    = 17;
  localparam int PaddrW  = 3;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_MARK  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic REG_FIRST_FRAME = 1'b0;
  localparam logic REG_END_FRAME   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CONV,
    ST_SETUP,
    ST_SEVAL,
    ST_SREAD,
    ST_MREAD,
    ST_MWRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic clr;
    logic div;
    logic setup;
    logic rd;
    logic seval;
    logic wr;
    logic succ;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_nop;
    logic run_done;
    logic run_fail;
    logic wrap;
  } sts_t;

endpackage

// File: src/bffa_ctrl.sv
// ---------------------------------------------------------------------------
// Bitmap first-fit frame allocator: controller
// Sequences the clearing pass, the frame-to-line conversion, the first-fit
// search and the read-modify-write pass over the bitmap lines.
// ---------------------------------------------------------------------------
module bffa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bffa_pkg::sts_t  sts_i,
  output bffa_pkg::cmd_t  cmd_o,
  output logic            busy_o,
  output logic            done_o
);
  import bffa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (sts_i.is_nop) begin
          state_d = ST_DONE;
        end else if (sts_i.is_alloc) begin
          state_d = ST_SEVAL;
        end else begin
          state_d = ST_MREAD;
        end
      end
      ST_SEVAL: begin
        if (sts_i.run_done) begin
          cmd_o.succ = 1'b1;
          state_d    = ST_MREAD;
        end else if (sts_i.run_fail) begin
          cmd_o.fail = 1'b1;
          state_d    = ST_DONE;
        end else if (sts_i.wrap) begin
          state_d = ST_SREAD;
        end else begin
          cmd_o.seval = 1'b1;
        end
      end
      ST_SREAD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SEVAL;
      end
      ST_MREAD: begin
        if (sts_i.run_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_MWRITE;
        end
      end
      ST_MWRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_MREAD;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

// File: src/bffa_dpath.sv
// ---------------------------------------------------------------------------
// Bitmap first-fit frame allocator: datapath
// Bitmap memory, reciprocal frame-to-line divider, run position counters,
// window mask and result registers.
// ---------------------------------------------------------------------------
module bffa_dpath #(
  parameter int MAP_FRAMES = 65536,
  parameter int LINE_BITS  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   func_i,
  input  logic [bffa_pkg::SrcW-1:0]    start_frame_i,
  input  logic [bffa_pkg::CountW-1:0]  frame_count_i,
  input  logic [bffa_pkg::SrcW-1:0]    first_frame_i,
  input  logic [bffa_pkg::EndW-1:0]    end_frame_i,
  input  bffa_pkg::cmd_t               cmd_i,
  output bffa_pkg::sts_t               sts_o,
  output logic [bffa_pkg::SrcW-1:0]    result_frame_o,
  output logic                         status_o
);
  import bffa_pkg::*;

  localparam int MapLines = (MAP_FRAMES + LINE_BITS - 1) / LINE_BITS;
  localparam int AddrW    = (MapLines > 1) ? $clog2(MapLines) : 1;
  localparam int LineW    = (AddrW > FrameW) ? AddrW : FrameW;
  localparam int IdxW     = $clog2(LINE_BITS);
  localparam int OffW     = $clog2(LINE_BITS + 1);
  localparam int DivSh    = SrcW + $clog2(LINE_BITS);
  localparam int RecipW   = SrcW + 1;
  localparam int ProdW    = SrcW + RecipW;

  localparam logic [OffW-1:0]   LineLen  = OffW'(LINE_BITS);
  localparam logic [LineW-1:0]  LastLine = LineW'(MapLines - 1);
  localparam logic [FrameW-1:0] NumCap   =
    (MAP_FRAMES < (1 << FrameW)) ? FrameW'(MAP_FRAMES) : '1;
  localparam logic [RecipW-1:0] Recip    =
    RecipW'(((1 << DivSh) + LINE_BITS - 1) / LINE_BITS);
  localparam logic [SrcW-1:0]   LineStep = SrcW'(LINE_BITS);

  function automatic logic [LINE_BITS-1:0] low_mask(input logic [OffW-1:0] k);
    logic [LINE_BITS:0] t;
    t = (LINE_BITS + 1)'(1) << k;
    t = t - (LINE_BITS + 1)'(1);
    return t[LINE_BITS-1:0];
  endfunction

  logic [LINE_BITS-1:0] mem_q [MapLines];
  logic [LINE_BITS-1:0] rdata_q;

  logic [1:0]         func_q;
  logic [CountW-1:0]  count_q;
  logic [SrcW-1:0]    src_q;
  logic [SrcW-1:0]    quo_q;
  logic [FrameW-1:0]  limit_q;
  logic [FrameW-1:0]  stop_q;
  logic [FrameW-1:0]  pos_q;
  logic [FrameW-1:0]  cand_q;
  logic [FrameW-1:0]  cnt1_q;
  logic [LineW-1:0]   line_q;
  logic [LineW-1:0]   cand_line_q;
  logic [IdxW-1:0]    off_q;
  logic [IdxW-1:0]    cand_off_q;
  logic               wrap_q;
  logic [SrcW-1:0]    result_q;
  logic               status_q;

  logic [ProdW-1:0]     div_prod;
  logic [SrcW-1:0]      div_quo;
  logic [SrcW-1:0]      line_base;
  logic [IdxW-1:0]      bit_off;
  logic [FrameW-1:0]    span;
  logic [OffW-1:0]      room;
  logic [OffW-1:0]      win;
  logic [OffW-1:0]      hi;
  logic [LINE_BITS-1:0] mask;
  logic                 hit;
  logic                 bit_used;
  logic [OffW-1:0]      adv;
  logic [OffW-1:0]      off_sum;
  logic                 wrapv;
  logic [IdxW-1:0]      off_nxt;
  logic [LineW-1:0]     line_nxt;
  logic [FrameW-1:0]    pos_nxt;
  logic [FrameW-1:0]    run_end;
  logic                 set_bits;
  logic                 mem_we;
  logic [LINE_BITS-1:0] mem_wdata;
  logic [AddrW-1:0]     addr;

  // line index by reciprocal multiply, bit offset from the line base
  always_comb begin
    div_prod  = ProdW'(src_q) * ProdW'(Recip);
    div_quo   = SrcW'(div_prod >> DivSh);
    line_base = quo_q * LineStep;
    bit_off   = IdxW'(src_q - line_base);
  end

  // window from the current bit to the line end or the run end
  always_comb begin
    span     = stop_q - pos_q;
    room     = LineLen - OffW'(off_q);
    win      = (span < FrameW'(room)) ? OffW'(span) : room;
    hi       = OffW'(off_q) + win;
    mask     = low_mask(hi) & ~low_mask(OffW'(off_q));
    hit      = |(rdata_q & mask);
    bit_used = rdata_q[off_q];
    adv      = (cmd_i.seval && hit) ? OffW'(1) : win;
    off_sum  = OffW'(off_q) + adv;
    wrapv    = (off_sum == LineLen);
    off_nxt  = wrapv ? '0 : IdxW'(off_sum);
    line_nxt = line_q + LineW'(wrapv);
    pos_nxt  = pos_q + FrameW'(adv);
    run_end  = FrameW'(src_q) + FrameW'(count_q);
  end

  assign set_bits  = (func_q != FUNC_FREE);
  assign mem_we    = cmd_i.clr | cmd_i.wr;
  assign mem_wdata = cmd_i.clr ? '0 : (set_bits ? (rdata_q | mask) : (rdata_q & ~mask));
  assign addr      = AddrW'(line_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      wrap_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        line_q <= (line_q == LastLine) ? '0 : line_q + LineW'(1);
      end
      if (cmd_i.setup) begin
        line_q <= LineW'(quo_q);
        wrap_q <= 1'b1;
      end
      if (cmd_i.seval) begin
        line_q <= line_nxt;
        if (wrapv) begin
          wrap_q <= 1'b1;
        end
      end
      if (cmd_i.rd) begin
        wrap_q <= 1'b0;
      end
      if (cmd_i.succ) begin
        line_q <= cand_line_q;
      end
      if (cmd_i.wr) begin
        line_q <= line_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      count_q  <= frame_count_i;
      src_q    <= (func_i == FUNC_ALLOC) ? first_frame_i : start_frame_i;
      limit_q  <= (FrameW'(end_frame_i) < NumCap) ? FrameW'(end_frame_i) : NumCap;
      result_q <= '0;
      status_q <= 1'b0;
    end
    if (cmd_i.div) begin
      quo_q <= div_quo;
    end
    if (cmd_i.setup) begin
      pos_q       <= FrameW'(src_q);
      cand_q      <= FrameW'(src_q);
      cand_line_q <= LineW'(quo_q);
      off_q       <= bit_off;
      cand_off_q  <= bit_off;
      cnt1_q      <= FrameW'(count_q) + FrameW'(1);
      stop_q      <= ((func_q == FUNC_ALLOC) || (run_end < NumCap)) ? run_end : NumCap;
    end
    if (cmd_i.seval) begin
      pos_q <= pos_nxt;
      off_q <= off_nxt;
      if (hit && bit_used) begin
        cand_q      <= pos_nxt;
        cand_line_q <= line_nxt;
        cand_off_q  <= off_nxt;
        stop_q      <= pos_q + cnt1_q;
      end
    end
    if (cmd_i.succ) begin
      pos_q    <= cand_q;
      off_q    <= cand_off_q;
      result_q <= cand_q[SrcW-1:0];
    end
    if (cmd_i.fail) begin
      status_q <= 1'b1;
    end
    if (cmd_i.wr) begin
      pos_q <= pos_nxt;
      off_q <= off_nxt;
    end
  end

  always_comb begin
    sts_o.clr_last = (line_q == LastLine);
    sts_o.is_alloc = (func_q == FUNC_ALLOC);
    sts_o.is_nop   = (func_q == FUNC_NOP);
    sts_o.run_done = (pos_q >= stop_q);
    sts_o.run_fail = (stop_q > limit_q);
    sts_o.wrap     = wrap_q;
  end

  assign result_frame_o = result_q;
  assign status_o       = status_q;

endmodule

// File: src/bitmap_first_fit_frame_allocator.sv
// ---------------------------------------------------------------------------
// Bitmap first-fit frame allocator: top level
// Allocate, free and mark runs of physical frames in a one-bit-per-frame map.
// ---------------------------------------------------------------------------
// Usage:
//   Drive func_i, start_frame_i and frame_count_i with start; the command
//   transfers at a clock edge with start high and busy low. done_o is high for
//   one cycle with result_frame_o and status_o; there is no back-pressure.
//   APB registers first_frame (0x0) and end_frame (0x4) must be written only
//   while busy is low; the block itself does not enforce it. pready is tied high.
// Sequence (one command in flight at a time, busy low again after done_o):
//   A command converts the first frame into a line and bit position, sets up,
//   runs its search or marking pass and returns the result; a no-op skips the pass.
//   Allocate search: a bitmap line free over the window is read and passed at
//   once; a line with used frames is stepped frame by frame; a last step decides.
//   Free, mark and the marking of a found run: each line touched is read, then
//   written on the single bitmap port, and a closing step ends the pass.
// Reset:
//   A clearing pass writes every bitmap line (1024 by default) to zero, one
//   line per cycle; busy stays high for it.
// ---------------------------------------------------------------------------
`include "bitmap_first_fit_frame_allocator_defines.svh"

module bitmap_first_fit_frame_allocator #(
  parameter int MAP_FRAMES = 65536,
  parameter int LINE_BITS  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bffa_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func_i,
  input  logic [bffa_pkg::SrcW-1:0]    start_frame_i,
  input  logic [bffa_pkg::CountW-1:0]  frame_count_i,
  output logic                         done_o,
  output logic [bffa_pkg::SrcW-1:0]    result_frame_o,
  output logic                         status_o
);
  import bffa_pkg::*;

  logic [SrcW-1:0] first_frame_q;
  logic [EndW-1:0] end_frame_q;
  logic            cfg_we;
  cmd_t            cmd;
  sts_t            sts;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_frame_q <= '0;
      end_frame_q   <= EndW'(1 << SrcW);
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_FIRST_FRAME: first_frame_q <= pwdata[SrcW-1:0];
        REG_END_FRAME:   end_frame_q   <= pwdata[EndW-1:0];
        default:         first_frame_q <= first_frame_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIRST_FRAME: prdata = 32'(first_frame_q);
      REG_END_FRAME:   prdata = 32'(end_frame_q);
      default:         prdata = '0;
    endcase
  end

  bffa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bffa_dpath #(
    .MAP_FRAMES (MAP_FRAMES),
    .LINE_BITS  (LINE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .func_i         (func_i),
    .start_frame_i  (start_frame_i),
    .frame_count_i  (frame_count_i),
    .first_frame_i  (first_frame_q),
    .end_frame_i    (end_frame_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_frame_o (result_frame_o),
    .status_o       (status_o)
  );

  `BFFA_ASSERT_NEXT(a_done_then_idle, done_o, !busy, "result not followed by idle")
  `BFFA_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy && !done_o, "command dropped")
  `BFFA_ASSERT_NOW(a_done_while_busy, done_o, busy, "result outside a command")
  `BFFA_ASSERT_NOW(a_fail_zero_frame, done_o && status_o, result_frame_o == '0, "fail with frame")

endmodule
